@@ rtl/bsbc_pkg.sv @@
`default_nettype none

package bsbc_pkg;

    // Geometry
    localparam int MAX_ROW_BYTES = 1024;
    localparam int WINDOW_ROWS   = 5;
    localparam int STORE_ROWS    = WINDOW_ROWS - 1;

    // Field widths
    localparam int PIX_W       = 8;
    localparam int WIDTH_REG_W = 11;
    localparam int ROW_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // One line-store word: STORE_ROWS bytes per bitmap, two bitmaps
    localparam int LANE_W = STORE_ROWS * PIX_W;
    localparam int WORD_W = 2 * LANE_W;

    typedef logic [PIX_W-1:0] t_pix;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH_BYTES = 2'd0,
        CFG_HEIGHT_ROWS = 2'd1
    } t_cfg_idx;

    // 5-pixel groups inside a byte
    localparam int NUM_GROUPS = 4;
    localparam logic [NUM_GROUPS-1:0][PIX_W-1:0] GROUP_MASKS =
        {8'h1f, 8'h3e, 8'h7c, 8'hf8};

    // Solid in one bitmap (AND of window) and empty in the other (OR of window)
    function automatic logic group_fails(input t_pix and_a, input t_pix or_b);
        logic hit;
        hit = 1'b0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            if (((and_a & GROUP_MASKS[g]) == GROUP_MASKS[g]) &&
                ((or_b & GROUP_MASKS[g]) == '0)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bitmap_solid_block_compare_top.sv @@
// Compares two 1-bit-per-pixel bitmaps that stream in together, one byte of each
// per transfer, in raster order. From the fifth row onward every byte column is
// checked against the five-row window ending at the current row; a 5x5 block that
// is solid in one bitmap and empty in the other marks the image as failed. One
// verdict transfer (images_match) follows the last byte of the image. The block
// takes one byte pair per cycle, but for the stall below: the line store is one
// word per column (four stored bytes of each bitmap) on a single read and a single
// write port, read when a byte pair is accepted and written back with the new byte
// as it leaves stage 1, with a bypass when the same column comes back at once
// (one-byte rows). The verdict is registered as the last byte leaves stage 1.
// The input stalls only while the last byte of an image waits behind an earlier
// verdict that the output side is still stalling; it then moves on in the cycle
// that verdict is taken, so no other byte ever waits.
// A width or height write restarts the image; no clearing pass is needed after reset.
`default_nettype none

module bitmap_solid_block_compare_top #(
    parameter int MAX_ROW_BYTES = bsbc_pkg::MAX_ROW_BYTES
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Byte-pair input channel
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [bsbc_pkg::PIX_W-1:0]       i_byte_first,
    input  wire  [bsbc_pkg::PIX_W-1:0]       i_byte_second,
    // Verdict output channel
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic                             o_images_match,
    // Configuration write port
    input  wire                              i_cfg_we,
    input  wire  [bsbc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [bsbc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int COL_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int ROW_W  = bsbc_pkg::ROW_W;
    localparam int PIX_W  = bsbc_pkg::PIX_W;
    localparam int LANE_W = bsbc_pkg::LANE_W;
    localparam int WORD_W = bsbc_pkg::WORD_W;

    // Line store: per column, the last four bytes of each bitmap.
    // [LANE_W-1:0] first bitmap, [WORD_W-1:LANE_W] second; newest byte lowest.
    logic [WORD_W-1:0] r_mem [MAX_ROW_BYTES];

    // Effective geometry, stored as last index
    logic [COL_W-1:0] r_last_col;
    logic [ROW_W-1:0] r_last_row;

    // Raster position of the next byte
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // Stage 1: accepted byte pair plus line-store read data
    logic              r_s1_valid;
    logic [PIX_W-1:0]  r_s1_a;
    logic [PIX_W-1:0]  r_s1_b;
    logic [COL_W-1:0]  r_s1_col;
    logic              r_s1_check;
    logic              r_s1_last;
    logic [WORD_W-1:0] r_rd;
    logic              r_fwd_hit;
    logic [WORD_W-1:0] r_fwd_word;

    // Sticky fail flag and output register
    logic r_mismatch;
    logic r_out_valid;
    logic r_out_match;

    logic              in_xfer;
    logic              out_free;
    logic              s1_fire;
    logic              at_last_col;
    logic              at_last_row;
    logic [WORD_W-1:0] old_word;
    logic [WORD_W-1:0] n_word;
    logic [PIX_W-1:0]  and_a, or_a, and_b, or_b;
    logic              fail_now;
    logic [COL_W-1:0]  n_last_col;
    logic [ROW_W-1:0]  n_last_row;
    logic [bsbc_pkg::WIDTH_REG_W-1:0] cfg_width;

    // Handshake: the verdict waits in the output register while new bytes go on
    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_fire     = r_s1_valid && (!r_s1_last || out_free);
    assign o_in_stall  = r_s1_valid && !s1_fire;
    assign in_xfer     = i_in_valid && !o_in_stall;

    assign at_last_col = (r_col == r_last_col);
    assign at_last_row = (r_row == r_last_row);

    // Window: four stored rows plus the current byte
    always_comb begin
        old_word = r_fwd_hit ? r_fwd_word : r_rd;
        and_a = r_s1_a;
        or_a  = r_s1_a;
        and_b = r_s1_b;
        or_b  = r_s1_b;
        for (int k = 0; k < bsbc_pkg::STORE_ROWS; k++) begin
            and_a = and_a & old_word[k*PIX_W +: PIX_W];
            or_a  = or_a  | old_word[k*PIX_W +: PIX_W];
            and_b = and_b & old_word[LANE_W + k*PIX_W +: PIX_W];
            or_b  = or_b  | old_word[LANE_W + k*PIX_W +: PIX_W];
        end
        fail_now = r_s1_check &&
                   (bsbc_pkg::group_fails(and_a, or_b) || bsbc_pkg::group_fails(and_b, or_a));
        // Oldest byte drops out, new byte enters at the bottom
        n_word = {old_word[WORD_W-PIX_W-1:LANE_W], r_s1_b,
                  old_word[LANE_W-PIX_W-1:0], r_s1_a};
    end

    // Width 0 acts as 1, width above the store saturates
    always_comb begin
        cfg_width = i_cfg_data[bsbc_pkg::WIDTH_REG_W-1:0];
        if (cfg_width == '0) begin
            n_last_col = '0;
        end else if (32'(cfg_width) > 32'(MAX_ROW_BYTES)) begin
            n_last_col = COL_W'(MAX_ROW_BYTES - 1);
        end else begin
            n_last_col = COL_W'(cfg_width - 1'b1);
        end
        n_last_row = (i_cfg_data[ROW_W-1:0] == '0) ? '0 : (i_cfg_data[ROW_W-1:0] - 1'b1);
    end

    // Configuration and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= '0;
            r_last_row <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else if (i_cfg_we) begin
            case (bsbc_pkg::t_cfg_idx'(i_cfg_index))
                bsbc_pkg::CFG_WIDTH_BYTES: begin
                    r_last_col <= n_last_col;
                    r_col      <= '0;
                    r_row      <= '0;
                end
                bsbc_pkg::CFG_HEIGHT_ROWS: begin
                    r_last_row <= n_last_row;
                    r_col      <= '0;
                    r_row      <= '0;
                end
                default: ;
            endcase
        end else if (in_xfer) begin
            if (at_last_col) begin
                r_col <= '0;
                r_row <= at_last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload, line-store read and same-column bypass
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_a     <= i_byte_first;
            r_s1_b     <= i_byte_second;
            r_s1_col   <= r_col;
            r_s1_check <= (r_row >= ROW_W'(bsbc_pkg::STORE_ROWS));
            r_s1_last  <= at_last_col && at_last_row;
            r_rd       <= r_mem[r_col];
            r_fwd_hit  <= s1_fire && (r_s1_col == r_col);
            r_fwd_word <= n_word;
        end
    end

    // Line-store write-back
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_mem[r_s1_col] <= n_word;
        end
    end

    // Sticky fail flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mismatch <= 1'b0;
        end else if (i_cfg_we &&
                     (i_cfg_index == bsbc_pkg::CFG_WIDTH_BYTES ||
                      i_cfg_index == bsbc_pkg::CFG_HEIGHT_ROWS)) begin
            r_mismatch <= 1'b0;
        end else if (s1_fire) begin
            r_mismatch <= r_s1_last ? 1'b0 : (r_mismatch | fail_now);
        end
    end

    // Verdict output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_last) begin
            r_out_match <= !(r_mismatch | fail_now);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_images_match = r_out_match;

endmodule

`default_nettype wire

@@ rtl/bsbc_checker.sv @@
`default_nettype none

module bsbc_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              o_in_stall,
    input wire                              o_out_valid,
    input wire                              i_out_stall,
    input wire                              o_images_match
);

    // Stalled verdict stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("verdict dropped while stalled");

    // Stalled verdict keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_images_match))
        else $error("verdict changed while stalled");

    // Input backs up only behind a stalled verdict
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled verdict");

    // No verdict right out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("verdict valid after reset");

endmodule

bind bitmap_solid_block_compare_top bsbc_checker u_bsbc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_images_match (o_images_match)
);

`default_nettype wire

@@ test/bitmap_solid_block_compare_top_test.sv @@
module bitmap_solid_block_compare_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Random part size and the cycles left after the last verdict before a
    // config write or the end of the run (verdict and line-store write-back
    // land at the same edge, as the last byte leaves stage 1).
    localparam int unsigned RANDOM_ITEMS   = 900;
    localparam int unsigned RANDOM_IMAGES  = 40;
    localparam int unsigned SETTLE_CYCLES  = 4;

    // Register indexes with no register behind them
    localparam logic [bsbc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [bsbc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // How the bytes of one bitmap are filled
    typedef enum int {
        PAT_SOLID,   // mostly 0xff, sometimes one pixel off
        PAT_EMPTY,   // mostly 0x00, sometimes one pixel on
        PAT_NOISE,   // any byte
        PAT_COPY,    // same as the first bitmap
        PAT_INVERT   // complement of the first bitmap
    } t_pat;

    typedef struct {
        bsbc_pkg::t_pix pix_a;
        bsbc_pkg::t_pix pix_b;
    } t_byte_pair;

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           in_valid    = 1'b0;
    logic                           in_stall;
    bsbc_pkg::t_pix                 byte_first  = '0;
    bsbc_pkg::t_pix                 byte_second = '0;
    logic                           out_valid;
    logic                           out_stall   = 1'b0;
    logic                           images_match;
    logic                           cfg_we      = 1'b0;
    logic [bsbc_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [bsbc_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

    bitmap_solid_block_compare_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_byte_first   (byte_first),
        .i_byte_second  (byte_second),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_images_match (images_match),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Scoreboard state
    // ------------------------------------------------------------------
    t_byte_pair  byte_q[$];      // byte pairs waiting for the driver
    bit          verdict_q[$];   // predicted images_match values, oldest first
    int unsigned queued_items  = 0;
    int unsigned images_closed = 0;
    int unsigned fault_count   = 0;

    // Per-phase switches for stretches without any idling
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;

    // ------------------------------------------------------------------
    // Window predictor: own copy of the register file, the four stored
    // rows of both bitmaps, the raster position and the sticky fail flag
    // ------------------------------------------------------------------
    logic [bsbc_pkg::WIDTH_REG_W-1:0] reg_width  = 11'd1;
    logic [bsbc_pkg::ROW_W-1:0]       reg_height = 16'd1;
    bsbc_pkg::t_pix line_first  [bsbc_pkg::STORE_ROWS][bsbc_pkg::MAX_ROW_BYTES];
    bsbc_pkg::t_pix line_second [bsbc_pkg::STORE_ROWS][bsbc_pkg::MAX_ROW_BYTES];
    int unsigned col_at = 0;
    int unsigned row_at = 0;
    bit          block_mismatch = 1'b0;

    // True when some 5-pixel group is all ones in `solid` and all zeros in `empty`
    function automatic bit solid_vs_empty(bsbc_pkg::t_pix solid, bsbc_pkg::t_pix empty);
        bsbc_pkg::t_pix grp;
        for (int g = 0; g < 4; g++) begin
            grp = 8'hf8 >> g;
            if ((solid & grp) == grp && (empty & grp) == 8'h00)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void restart_image();
        col_at         = 0;
        row_at         = 0;
        block_mismatch = 1'b0;
    endfunction

    function automatic void apply_register_write(logic [bsbc_pkg::CFG_IDX_W-1:0] idx,
                                                 logic [bsbc_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            bsbc_pkg::CFG_WIDTH_BYTES: begin
                reg_width = data[bsbc_pkg::WIDTH_REG_W-1:0];
                restart_image();
            end
            bsbc_pkg::CFG_HEIGHT_ROWS: begin
                reg_height = data[bsbc_pkg::ROW_W-1:0];
                restart_image();
            end
            default: ;  // unmapped index: no effect, image keeps going
        endcase
    endfunction

    // One accepted byte pair: window check from the fifth row on, store the
    // bytes, advance the raster position and close the image at its end.
    function automatic void predict_window_check(bsbc_pkg::t_pix a, bsbc_pkg::t_pix b);
        int unsigned    w;
        int unsigned    h;
        int unsigned    slot;
        bsbc_pkg::t_pix and_a;
        bsbc_pkg::t_pix or_a;
        bsbc_pkg::t_pix and_b;
        bsbc_pkg::t_pix or_b;
        w = (reg_width == 0) ? 1 :
            (reg_width > bsbc_pkg::MAX_ROW_BYTES) ? bsbc_pkg::MAX_ROW_BYTES
                                                   : int'(reg_width);
        h = (reg_height == 0) ? 1 : int'(reg_height);
        slot = row_at % bsbc_pkg::STORE_ROWS;
        if (row_at >= bsbc_pkg::STORE_ROWS) begin
            and_a = a;
            or_a  = a;
            and_b = b;
            or_b  = b;
            for (int k = 0; k < bsbc_pkg::STORE_ROWS; k++) begin
                and_a &= line_first[k][col_at];
                or_a  |= line_first[k][col_at];
                and_b &= line_second[k][col_at];
                or_b  |= line_second[k][col_at];
            end
            if (solid_vs_empty(and_a, or_b) || solid_vs_empty(and_b, or_a))
                block_mismatch = 1'b1;
        end
        line_first[slot][col_at]  = a;
        line_second[slot][col_at] = b;
        if (col_at + 1 < w) begin
            col_at++;
        end else begin
            col_at = 0;
            if (row_at + 1 < h) begin
                row_at++;
            end else begin
                verdict_q.push_back(!block_mismatch);
                images_closed++;
                restart_image();
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // Idle length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void log_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endfunction

    function automatic bsbc_pkg::t_pix shade(t_pat p, bsbc_pkg::t_pix other);
        case (p)
            PAT_SOLID:  return ($urandom_range(0, 9) < 8) ? 8'hff
                                                          : ~(8'h01 << $urandom_range(0, 7));
            PAT_EMPTY:  return ($urandom_range(0, 9) < 8) ? 8'h00
                                                          : (8'h01 << $urandom_range(0, 7));
            PAT_COPY:   return other;
            PAT_INVERT: return ~other;
            default:    return bsbc_pkg::t_pix'($urandom);
        endcase
    endfunction

    function automatic void push_pair(bsbc_pkg::t_pix a, bsbc_pkg::t_pix b);
        byte_q.push_back('{pix_a: a, pix_b: b});
        queued_items++;
    endfunction

    // Queue `count` byte pairs of an image starting at raster index `first_idx`.
    // In column `hot_col` (if any) the first bitmap is solid and the second empty.
    function automatic void queue_bytes(int unsigned first_idx, int unsigned count,
                                        int unsigned width, t_pat pat_a, t_pat pat_b,
                                        int hot_col);
        bsbc_pkg::t_pix a;
        for (int unsigned i = 0; i < count; i++) begin
            if (int'((first_idx + i) % width) == hot_col) begin
                push_pair(8'hff, 8'h00);
            end else begin
                a = shade(pat_a, 8'h00);
                push_pair(a, shade(pat_b, a));
            end
        end
    endfunction

    // Register write on the plain write port; returns at a rising edge so a
    // following call never touches the same falling edge twice.
    task automatic write_reg(logic [bsbc_pkg::CFG_IDX_W-1:0] idx,
                             logic [bsbc_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        apply_register_write(idx, data);
        @(posedge clk);
    endtask

    // Sender holds off until every queued pair is in and every verdict is out,
    // then gives the block time to finish its line-store write-back.
    task automatic wait_quiet();
        do @(posedge clk);
        while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Input driver: one byte pair per transfer, random gaps between them.
    // A stalled pair stays on the bus untouched.
    // ------------------------------------------------------------------
    logic        in_taken = 1'b0;
    int unsigned send_gap = 0;

    always @(posedge clk) begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            predict_window_check(byte_first, byte_second);
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_taken) begin
            // stalled: hold valid and payload
        end else if (send_gap != 0) begin
            in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (byte_q.size() != 0) begin
            byte_first  <= byte_q[0].pix_a;
            byte_second <= byte_q[0].pix_b;
            void'(byte_q.pop_front());
            in_valid    <= 1'b1;
            send_gap    <= send_steady ? 0 : idle_len();
        end else begin
            in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Verdict side: random stall runs, check each transfer against the
    // oldest prediction.
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;

    always @(negedge clk) begin
        if (!rst_n || take_steady) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= idle_len();
        end else begin
            out_stall  <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (verdict_q.size() == 0) begin
                log_fault($sformatf("verdict with no image closed: images_match=%0b",
                                    images_match));
            end else begin
                if (images_match !== verdict_q[0])
                    log_fault($sformatf("verdict mismatch: expected images_match=%0b, got %0b",
                                        verdict_q[0], images_match));
                void'(verdict_q.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int unsigned    cur_w;
        int unsigned    cur_h;
        int unsigned    pick_w;
        int unsigned    pick_h;
        int unsigned    total;
        int unsigned    cut;
        int unsigned    sel;
        int unsigned    item_base;
        int unsigned    image_base;
        bsbc_pkg::t_pix grp;
        t_pat           pat_a;
        t_pat           pat_b;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry is one byte by one row: every pair is a short image
        // and must match, whatever the bytes are.
        push_pair(8'h00, 8'h00);
        push_pair(8'hff, 8'h00);
        push_pair(8'h00, 8'hff);
        push_pair(8'hff, 8'hff);
        wait_quiet();

        // Five rows of one byte: one image per 5-pixel group, solid in the
        // first bitmap for the left two groups and in the second for the others.
        write_reg(bsbc_pkg::CFG_HEIGHT_ROWS, 16'd5);
        for (int g = 0; g < 4; g++) begin
            grp = 8'hf8 >> g;
            repeat (5) begin
                if (g < 2) push_pair(grp, ~grp);
                else       push_pair(~grp, grp);
            end
        end
        wait_quiet();

        // Widest row: width register all ones saturates to the line-store size.
        // A single row, so solid-versus-empty bytes everywhere still match.
        write_reg(bsbc_pkg::CFG_HEIGHT_ROWS, 16'd1);
        write_reg(bsbc_pkg::CFG_WIDTH_BYTES, 16'hffff);
        queue_bytes(0, bsbc_pkg::MAX_ROW_BYTES, bsbc_pkg::MAX_ROW_BYTES,
                    PAT_SOLID, PAT_INVERT, -1);
        wait_quiet();

        // Tallest image, abandoned part way after a mismatch has been seen;
        // the next write has to clear the sticky flag.
        write_reg(bsbc_pkg::CFG_WIDTH_BYTES, {5'b10101, 11'd3});
        write_reg(bsbc_pkg::CFG_HEIGHT_ROWS, 16'hffff);
        queue_bytes(0, 45, 3, PAT_SOLID, PAT_INVERT, -1);
        wait_quiet();
        cur_w = 3;
        cur_h = 65535;

        // Random phases: new geometry, a few whole images, sometimes a write
        // to an unmapped index inside an image, sometimes a dropped image.
        item_base  = queued_items;
        image_base = images_closed;
        while (queued_items - item_base < RANDOM_ITEMS ||
               images_closed - image_base < RANDOM_IMAGES) begin
            send_steady = ($urandom_range(0, 4) == 0);
            take_steady = ($urandom_range(0, 4) == 0);

            sel = $urandom_range(0, 5);
            pick_w = $urandom_range(0, 99);
            pick_w = (pick_w < 5) ? 0 : (pick_w < 20) ? 1 : $urandom_range(2, 8);
            pick_h = $urandom_range(0, 99);
            pick_h = (pick_h < 8) ? 0 : (pick_h < 20) ? $urandom_range(1, 4)
                                                      : $urandom_range(5, 12);
            if (sel != 0) begin
                write_reg(bsbc_pkg::CFG_WIDTH_BYTES, {5'($urandom), 11'(pick_w)});
                cur_w = (pick_w == 0) ? 1 : pick_w;
            end
            if (sel != 1 || cur_h > 12) begin
                write_reg(bsbc_pkg::CFG_HEIGHT_ROWS, 16'(pick_h));
                cur_h = (pick_h == 0) ? 1 : pick_h;
            end
            total = cur_w * cur_h;

            repeat ($urandom_range(1, 4)) begin
                pat_a = t_pat'($urandom_range(0, 2));
                pat_b = t_pat'($urandom_range(0, 4));
                if (total > 1 && $urandom_range(0, 3) == 0) begin
                    cut = $urandom_range(1, total - 1);
                    queue_bytes(0, cut, cur_w, pat_a, pat_b, -1);
                    wait_quiet();
                    write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                              16'($urandom));
                    queue_bytes(cut, total - cut, cur_w, pat_a, pat_b, -1);
                end else begin
                    queue_bytes(0, total, cur_w, pat_a, pat_b, -1);
                end
            end

            // Dropped image: the next register write abandons it
            if (total > 1 && $urandom_range(0, 4) == 0)
                queue_bytes(0, $urandom_range(1, total - 1), cur_w,
                            t_pat'($urandom_range(0, 2)), t_pat'($urandom_range(0, 4)), -1);
            wait_quiet();
        end

        send_steady = 1'b0;
        take_steady = 1'b0;
        wait_quiet();
        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #25ms;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/bsbc_pkg.sv
rtl/bitmap_solid_block_compare_top.sv
rtl/bsbc_checker.sv
test/bitmap_solid_block_compare_top_test.sv
